[rtl/core/i2cbe_pkg.sv]
// Shared types, codes and phase tables of the I2C master bit engine.
`default_nettype none

package i2cbe_pkg;

   localparam int BITS_PER_BYTE = 8;
   localparam logic [15:0] PHASE_TICKS_RESET = 16'd10;

   // Command codes; IDLE marks no command running
   typedef enum logic [2:0] {
      ACT_START = 3'd0,
      ACT_STOP  = 3'd1,
      ACT_WRITE = 3'd2,
      ACT_READ  = 3'd3,
      ACT_SACK  = 3'd4,
      ACT_RACK  = 3'd5,
      ACT_IDLE  = 3'd7
   } action_type;

   // Bit slot within a byte phase group; write: drive SDA / raise SCL / lower SCL
   typedef enum logic [1:0] {
      SLOT_FIRST  = 2'd0,
      SLOT_MIDDLE = 2'd1,
      SLOT_LAST   = 2'd2
   } slot_type;

   // Engine state carried from tick to tick
   typedef struct packed {
      action_type  act;
      logic [4:0]  phase;
      logic [15:0] tick;
      slot_type    slot;
      logic [2:0]  bit_idx;
      logic [7:0]  shift;
      logic        scl;
      logic        sda;
      logic        ack;
      logic [7:0]  read_hold;
      logic        sack_level;
   } engine_state_type;

   // One input beat
   typedef struct packed {
      logic       cmd_valid;
      logic [2:0] action;
      logic [7:0] write_byte;
      logic       ack_level;
      logic       sda_in;
   } tick_type;

   // One result beat
   typedef struct packed {
      logic       scl_level;
      logic       sda_level;
      logic       busy_res;
      logic       done_res;
      logic [7:0] read_byte;
      logic       ack_received;
      logic       cmd_ignored;
   } result_type;

   localparam engine_state_type STATE_RESET = '{
      act:        ACT_IDLE,
      phase:      5'd0,
      tick:       16'd0,
      slot:       SLOT_FIRST,
      bit_idx:    3'd0,
      shift:      8'd0,
      scl:        1'b1,
      sda:        1'b1,
      ack:        1'b0,
      read_hold:  8'd0,
      sack_level: 1'b1
   };

   // Number of pin phases in each command
   function automatic logic [4:0] phase_total(input action_type act);
      logic [4:0] total;
      unique case (act)
         ACT_START: total = 5'd4;
         ACT_STOP:  total = 5'd3;
         ACT_WRITE: total = 5'(3 * BITS_PER_BYTE);
         ACT_READ:  total = 5'(1 + 3 * BITS_PER_BYTE);
         ACT_SACK:  total = 5'd3;
         ACT_RACK:  total = 5'd4;
         default:   total = 5'd0;
      endcase
      return total;
   endfunction

endpackage

`default_nettype wire

[rtl/core/i2cbe_step.sv]
// One tick of the I2C bit engine: next state and result from current state.
`default_nettype none

module i2cbe_step (
   input  wire  i2cbe_pkg::engine_state_type cur_state,
   input  wire  i2cbe_pkg::tick_type         tick_beat,
   input  wire  logic [15:0]                 phase_ticks,
   output       i2cbe_pkg::engine_state_type nxt_state,
   output       i2cbe_pkg::result_type       result
);
   import i2cbe_pkg::*;

   logic [15:0] phase_len;
   logic [16:0] tick_inc;
   logic [4:0]  k;
   logic        run;
   logic        done;
   logic        ignored;
   logic [2:0]  bit_pos;

   always_comb begin
      nxt_state = cur_state;
      done      = 1'b0;
      ignored   = 1'b0;
      run       = 1'b0;
      k         = cur_state.phase;
      phase_len = (phase_ticks == 16'd0) ? 16'd1 : phase_ticks;
      tick_inc  = {1'b0, cur_state.tick} + 17'd1;

      // Running command: count ticks, step to next phase at phase end
      if (cur_state.act != ACT_IDLE) begin
         ignored = tick_beat.cmd_valid;
         if (tick_inc >= {1'b0, phase_len}) begin
            nxt_state.tick  = 16'd0;
            k               = cur_state.phase + 5'd1;
            nxt_state.phase = k;
            if (cur_state.slot == SLOT_LAST) begin
               nxt_state.slot    = SLOT_FIRST;
               nxt_state.bit_idx = cur_state.bit_idx + 3'd1;
            end else begin
               nxt_state.slot = slot_type'(cur_state.slot + 2'd1);
            end
            if (k >= phase_total(cur_state.act)) begin
               if (cur_state.act == ACT_READ) nxt_state.read_hold = cur_state.shift;
               done            = 1'b1;
               nxt_state.act   = ACT_IDLE;
               nxt_state.phase = 5'd0;
            end else begin
               run = 1'b1;
            end
         end else begin
            nxt_state.tick = tick_inc[15:0];
         end
      // Idle: take a legal command, drop an unknown one
      end else if (tick_beat.cmd_valid) begin
         if (tick_beat.action <= 3'(ACT_RACK)) begin
            nxt_state.act   = action_type'(tick_beat.action);
            nxt_state.phase = 5'd0;
            nxt_state.tick  = 16'd0;
            k               = 5'd0;
            if (action_type'(tick_beat.action) == ACT_WRITE) begin
               nxt_state.shift   = tick_beat.write_byte;
               nxt_state.slot    = SLOT_FIRST;
               nxt_state.bit_idx = 3'd0;
            end else begin
               // read: the SDA release phase precedes bit 0, so wrap into it
               if (action_type'(tick_beat.action) == ACT_READ) nxt_state.shift = 8'd0;
               nxt_state.slot    = SLOT_LAST;
               nxt_state.bit_idx = 3'd7;
            end
            if (action_type'(tick_beat.action) == ACT_SACK) begin
               nxt_state.sack_level = tick_beat.ack_level;
            end
            run = 1'b1;
         end else begin
            ignored = 1'b1;
         end
      end

      // Pin action of the phase just entered; MSB first
      bit_pos = 3'd7 - nxt_state.bit_idx;
      if (run) begin
         case (nxt_state.act)
            ACT_START: begin
               if (k == 5'd0)      nxt_state.sda = 1'b1;
               else if (k == 5'd1) nxt_state.scl = 1'b1;
               else if (k == 5'd2) nxt_state.sda = 1'b0;
               else                nxt_state.scl = 1'b0;
            end
            ACT_STOP: begin
               if (k == 5'd0)      nxt_state.sda = 1'b0;
               else if (k == 5'd1) nxt_state.scl = 1'b1;
               else                nxt_state.sda = 1'b1;
            end
            ACT_WRITE: begin
               if (nxt_state.slot == SLOT_FIRST)       nxt_state.sda = nxt_state.shift[bit_pos];
               else if (nxt_state.slot == SLOT_MIDDLE) nxt_state.scl = 1'b1;
               else                                    nxt_state.scl = 1'b0;
            end
            ACT_READ: begin
               if (k == 5'd0) begin
                  nxt_state.sda = 1'b1;
               end else if (nxt_state.slot == SLOT_FIRST) begin
                  nxt_state.scl = 1'b1;
               end else if (nxt_state.slot == SLOT_MIDDLE) begin
                  if (tick_beat.sda_in) nxt_state.shift[bit_pos] = 1'b1;
               end else begin
                  nxt_state.scl = 1'b0;
               end
            end
            ACT_SACK: begin
               if (k == 5'd0)      nxt_state.sda = nxt_state.sack_level;
               else if (k == 5'd1) nxt_state.scl = 1'b1;
               else                nxt_state.scl = 1'b0;
            end
            ACT_RACK: begin
               if (k == 5'd0)      nxt_state.sda = 1'b1;
               else if (k == 5'd1) nxt_state.scl = 1'b1;
               else if (k == 5'd2) nxt_state.ack = tick_beat.sda_in;
               else                nxt_state.scl = 1'b0;
            end
            default: ;
         endcase
      end

      // Result beat reflects the state after this tick
      result.scl_level    = nxt_state.scl;
      result.sda_level    = nxt_state.sda;
      result.busy_res     = (nxt_state.act != ACT_IDLE);
      result.done_res     = done;
      result.read_byte    = nxt_state.read_hold;
      result.ack_received = nxt_state.ack;
      result.cmd_ignored  = ignored;
   end

endmodule

`default_nettype wire

[rtl/core/i2c_master_bit_engine_unit.sv]
// Top level of the I2C master bit engine: handshakes, registers and config.
//
// Each request beat is one time tick, optionally carrying a command (start, stop,
// write byte, read byte, send ack, receive ack); each tick yields exactly one
// response beat with the open-drain SCL/SDA drive levels, busy, a done pulse,
// the last read byte, the last received ack and a dropped-command flag. Ticks
// are taken one per clock cycle unless rsp_stall holds back the response: a tick
// is captured in an input register, then one short combinational step updates
// the engine state and loads the response register. The input register keeps
// taking beats while a response waits under rsp_stall, until it holds one.
// csr_wdata sets the pin phase length in ticks (0 acts as 1, reset 10); write it
// only while the engine is idle.
`default_nettype none

module i2c_master_bit_engine_unit (
   input  wire  logic        clock,
   input  wire  logic        reset,
   // tick input
   input  wire  logic        req_valid,
   output       logic        req_stall,
   input  wire  logic        req_cmd_valid,
   input  wire  logic [2:0]  req_action,
   input  wire  logic [7:0]  req_write_byte,
   input  wire  logic        req_ack_level,
   input  wire  logic        req_sda_in,
   // result output
   output       logic        rsp_valid,
   input  wire  logic        rsp_stall,
   output       logic        rsp_scl_level,
   output       logic        rsp_sda_level,
   output       logic        rsp_busy_res,
   output       logic        rsp_done_res,
   output       logic [7:0]  rsp_read_byte,
   output       logic        rsp_ack_received,
   output       logic        rsp_cmd_ignored,
   // phase length register
   input  wire  logic        csr_valid,
   output       logic        csr_ready,
   input  wire  logic [15:0] csr_wdata
);
   import i2cbe_pkg::*;

   logic             in_valid_ff, in_valid_in;
   tick_type         in_beat_ff;
   logic             out_valid_ff, out_valid_in;
   result_type       out_beat_ff;
   engine_state_type state_ff, state_in;
   result_type       step_result;
   logic [15:0]      phase_ticks_ff;
   logic             fire;
   logic             load;

   // Flow control: step fires when the response register is free or draining
   assign fire        = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall   = in_valid_ff && !fire;
   assign load        = req_valid && !req_stall;
   assign in_valid_in = load ? 1'b1 : (fire ? 1'b0 : in_valid_ff);
   assign out_valid_in = fire ? 1'b1 : (rsp_stall ? out_valid_ff : 1'b0);
   assign csr_ready   = 1'b1;

   i2cbe_step u_step (
      .cur_state   (state_ff),
      .tick_beat   (in_beat_ff),
      .phase_ticks (phase_ticks_ff),
      .nxt_state   (state_in),
      .result      (step_result)
   );

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         out_valid_ff   <= 1'b0;
         state_ff       <= STATE_RESET;
         phase_ticks_ff <= PHASE_TICKS_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (fire) state_ff <= state_in;
         if (csr_valid && csr_ready) phase_ticks_ff <= csr_wdata;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (load) begin
         in_beat_ff.cmd_valid  <= req_cmd_valid;
         in_beat_ff.action     <= req_action;
         in_beat_ff.write_byte <= req_write_byte;
         in_beat_ff.ack_level  <= req_ack_level;
         in_beat_ff.sda_in     <= req_sda_in;
      end
      if (fire) out_beat_ff <= step_result;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_scl_level    = out_beat_ff.scl_level;
   assign rsp_sda_level    = out_beat_ff.sda_level;
   assign rsp_busy_res     = out_beat_ff.busy_res;
   assign rsp_done_res     = out_beat_ff.done_res;
   assign rsp_read_byte    = out_beat_ff.read_byte;
   assign rsp_ack_received = out_beat_ff.ack_received;
   assign rsp_cmd_ignored  = out_beat_ff.cmd_ignored;

endmodule

`default_nettype wire

[tb/i2c_master_bit_engine_unit_tb.sv]
// Self-checking testbench for the I2C master bit engine: tick stream in, pin status out.
module i2c_master_bit_engine_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import i2cbe_pkg::*;

   // clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;
   always #10 clock = ~clock;

   // block ports
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_cmd_valid = 1'b0;
   logic [2:0]  req_action = 3'd0;
   logic [7:0]  req_write_byte = 8'd0;
   logic        req_ack_level = 1'b0;
   logic        req_sda_in = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_scl_level;
   logic        rsp_sda_level;
   logic        rsp_busy_res;
   logic        rsp_done_res;
   logic [7:0]  rsp_read_byte;
   logic        rsp_ack_received;
   logic        rsp_cmd_ignored;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [15:0] csr_wdata = 16'd0;

   i2c_master_bit_engine_unit uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_cmd_valid    (req_cmd_valid),
      .req_action       (req_action),
      .req_write_byte   (req_write_byte),
      .req_ack_level    (req_ack_level),
      .req_sda_in       (req_sda_in),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_scl_level    (rsp_scl_level),
      .rsp_sda_level    (rsp_sda_level),
      .rsp_busy_res     (rsp_busy_res),
      .rsp_done_res     (rsp_done_res),
      .rsp_read_byte    (rsp_read_byte),
      .rsp_ack_received (rsp_ack_received),
      .rsp_cmd_ignored  (rsp_cmd_ignored),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_wdata        (csr_wdata)
   );

   // engine mirror: state and phase length register
   action_type  eng_act;
   logic [4:0]  eng_phase;
   logic [15:0] eng_tick;
   logic [7:0]  eng_shift;
   logic        pin_scl;
   logic        pin_sda;
   logic        ack_seen;
   logic        sack_lvl;
   logic [7:0]  read_latch;
   logic [15:0] phase_len;

   tick_type    tick_backlog[$];
   result_type  expected_status[$];
   int          fail_count = 0;
   bit          quiet = 1'b0;
   bit          noise_on = 1'b0;

   // ticks per phase as the engine sees it
   function automatic int eff_len();
      return (phase_len == 16'd0) ? 1 : int'(phase_len);
   endfunction

   function automatic int phase_count(input logic [2:0] act);
      case (act)
         ACT_START: return 4;
         ACT_STOP:  return 3;
         ACT_WRITE: return 3 * BITS_PER_BYTE;
         ACT_READ:  return 1 + 3 * BITS_PER_BYTE;
         ACT_SACK:  return 3;
         ACT_RACK:  return 4;
         default:   return 0;
      endcase
   endfunction

   // pin action of phase k of the running command, done on its first tick
   function automatic void apply_phase(input logic [4:0] k, input logic sda_bit);
      int kk;
      int slot;
      int bit_pos;
      kk = int'(k);
      case (eng_act)
         ACT_START: begin
            if (kk == 0) pin_sda = 1'b1;
            else if (kk == 1) pin_scl = 1'b1;
            else if (kk == 2) pin_sda = 1'b0;
            else pin_scl = 1'b0;
         end
         ACT_STOP: begin
            if (kk == 0) pin_sda = 1'b0;
            else if (kk == 1) pin_scl = 1'b1;
            else pin_sda = 1'b1;
         end
         ACT_WRITE: begin
            slot = kk % 3;
            bit_pos = BITS_PER_BYTE - 1 - kk / 3;
            if (slot == 0) pin_sda = eng_shift[bit_pos];
            else if (slot == 1) pin_scl = 1'b1;
            else pin_scl = 1'b0;
         end
         ACT_READ: begin
            if (kk == 0) begin
               pin_sda = 1'b1;
            end else begin
               slot = (kk - 1) % 3;
               bit_pos = BITS_PER_BYTE - 1 - (kk - 1) / 3;
               if (slot == 0) pin_scl = 1'b1;
               else if (slot == 1) begin
                  if (sda_bit) eng_shift[bit_pos] = 1'b1;
               end else pin_scl = 1'b0;
            end
         end
         ACT_SACK: begin
            if (kk == 0) pin_sda = sack_lvl;
            else if (kk == 1) pin_scl = 1'b1;
            else pin_scl = 1'b0;
         end
         ACT_RACK: begin
            if (kk == 0) pin_sda = 1'b1;
            else if (kk == 1) pin_scl = 1'b1;
            else if (kk == 2) ack_seen = sda_bit;
            else pin_scl = 1'b0;
         end
         default: ;
      endcase
   endfunction

   // advance the mirror by one tick and return the status it shows
   function automatic result_type engine_step(input tick_type t);
      result_type r;
      logic done_now;
      logic dropped;
      done_now = 1'b0;
      dropped = 1'b0;
      if (eng_act != ACT_IDLE) begin
         if (t.cmd_valid) dropped = 1'b1;
         if (int'(eng_tick) + 1 >= eff_len()) begin
            eng_tick = 16'd0;
            eng_phase = eng_phase + 5'd1;
            if (int'(eng_phase) >= phase_count(eng_act)) begin
               if (eng_act == ACT_READ) read_latch = eng_shift;
               done_now = 1'b1;
               eng_act = ACT_IDLE;
               eng_phase = 5'd0;
            end else begin
               apply_phase(eng_phase, t.sda_in);
            end
         end else begin
            eng_tick = eng_tick + 16'd1;
         end
      end else if (t.cmd_valid) begin
         if (t.action <= ACT_RACK) begin
            eng_act = action_type'(t.action);
            eng_phase = 5'd0;
            eng_tick = 16'd0;
            if (eng_act == ACT_WRITE) eng_shift = t.write_byte;
            else if (eng_act == ACT_READ) eng_shift = 8'd0;
            if (eng_act == ACT_SACK) sack_lvl = t.ack_level;
            apply_phase(5'd0, t.sda_in);
         end else begin
            dropped = 1'b1;
         end
      end
      r.scl_level = pin_scl;
      r.sda_level = pin_sda;
      r.busy_res = (eng_act != ACT_IDLE);
      r.done_res = done_now;
      r.read_byte = read_latch;
      r.ack_received = ack_seen;
      r.cmd_ignored = dropped;
      return r;
   endfunction

   function automatic void check_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         fail_count++;
      end
   endfunction

   // acceptance on both channels, sampled at the rising edge
   logic       req_taken = 1'b0;
   tick_type   seen_tick;
   result_type want_res;
   result_type got_res;

   always @(posedge clock) begin
      req_taken <= req_valid && !req_stall;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            seen_tick = tick_type'({req_cmd_valid, req_action, req_write_byte,
                                    req_ack_level, req_sda_in});
            expected_status.push_back(engine_step(seen_tick));
         end
         if (rsp_valid && !rsp_stall) begin
            got_res = result_type'({rsp_scl_level, rsp_sda_level, rsp_busy_res,
                                    rsp_done_res, rsp_read_byte, rsp_ack_received,
                                    rsp_cmd_ignored});
            if (expected_status.size() == 0) begin
               $error("result beat with no expectation pending");
               fail_count++;
            end else begin
               want_res = expected_status.pop_front();
               check_field("scl_level", want_res.scl_level, got_res.scl_level);
               check_field("sda_level", want_res.sda_level, got_res.sda_level);
               check_field("busy_res", want_res.busy_res, got_res.busy_res);
               check_field("done_res", want_res.done_res, got_res.done_res);
               check_field("read_byte", want_res.read_byte, got_res.read_byte);
               check_field("ack_received", want_res.ack_received, got_res.ack_received);
               check_field("cmd_ignored", want_res.cmd_ignored, got_res.cmd_ignored);
            end
         end
      end
   end

   // tick driver: one beat held until taken, random idle bursts between beats
   int       send_gap = 0;
   tick_type next_tick;

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_taken) begin
         // beat stalled, hold it
      end else if (send_gap > 0) begin
         send_gap = send_gap - 1;
         req_valid <= 1'b0;
      end else if (tick_backlog.size() > 0) begin
         next_tick = tick_backlog.pop_front();
         req_cmd_valid <= next_tick.cmd_valid;
         req_action <= next_tick.action;
         req_write_byte <= next_tick.write_byte;
         req_ack_level <= next_tick.ack_level;
         req_sda_in <= next_tick.sda_in;
         req_valid <= 1'b1;
         if (!quiet && $urandom_range(0, 7) == 0) send_gap = $urandom_range(1, 9);
      end else begin
         req_valid <= 1'b0;
      end
   end

   // result backpressure in random bursts
   int stall_left = 0;

   always @(negedge clock) begin
      if (reset || quiet) begin
         stall_left = 0;
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left = stall_left - 1;
         rsp_stall <= 1'b1;
      end else if ($urandom_range(0, 7) == 0) begin
         stall_left = $urandom_range(0, 8);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // stimulus helpers
   function automatic void push_tick(input logic cv, input logic [2:0] act,
                                     input logic [7:0] wb, input logic ack,
                                     input logic sda);
      tick_type t;
      t.cmd_valid = cv;
      t.action = act;
      t.write_byte = wb;
      t.ack_level = ack;
      t.sda_in = sda;
      tick_backlog.push_back(t);
   endfunction

   function automatic logic pick_sda(input int sda_fix);
      return (sda_fix < 0) ? logic'($urandom_range(0, 1)) : logic'(sda_fix);
   endfunction

   function automatic int pad_jitter();
      return ($urandom_range(0, 15) == 0) ? -1 : int'($urandom_range(0, 3));
   endfunction

   // one command tick, then filler ticks up to the tick before its done tick, plus pad
   task automatic issue(input logic [2:0] act, input logic [7:0] wb, input logic ack,
                        input int sda_fix, input int pad, input bit poke_busy);
      int busy_ticks;
      int fill;
      busy_ticks = phase_count(act) * eff_len();
      if (busy_ticks == 0) fill = (pad > 0) ? pad : 0;
      else fill = busy_ticks - 1 + pad;
      push_tick(1'b1, act, wb, ack, pick_sda(sda_fix));
      for (int i = 1; i <= fill; i++) begin
         if (i == 1 && poke_busy && busy_ticks > 0)
            push_tick(1'b1, ACT_WRITE, $urandom, $urandom, pick_sda(sda_fix));
         else if (noise_on && i <= busy_ticks && $urandom_range(0, 31) == 0)
            push_tick(1'b1, $urandom_range(0, 7), $urandom, $urandom, pick_sda(sda_fix));
         else
            push_tick(1'b0, $urandom, $urandom, $urandom, pick_sda(sda_fix));
      end
   endtask

   // random traffic: mostly whole bus transactions, some lone commands
   task automatic random_traffic(input int budget);
      int stop_at;
      int n_bytes;
      stop_at = tick_backlog.size() + budget;
      while (tick_backlog.size() < stop_at) begin
         if ($urandom_range(0, 4) != 0) begin
            issue(ACT_START, $urandom, $urandom, -1, pad_jitter(), 1'b0);
            issue(ACT_WRITE, $urandom, $urandom, -1, pad_jitter(), 1'b0);
            issue(ACT_RACK, $urandom, $urandom, ($urandom_range(0, 3) == 0) ? 1 : 0,
                  pad_jitter(), 1'b0);
            n_bytes = $urandom_range(1, 3);
            repeat (n_bytes) begin
               if ($urandom_range(0, 1) == 0) begin
                  issue(ACT_WRITE, $urandom, $urandom, -1, pad_jitter(), 1'b0);
                  issue(ACT_RACK, $urandom, $urandom, -1, pad_jitter(), 1'b0);
               end else begin
                  issue(ACT_READ, $urandom, $urandom, -1, pad_jitter(), 1'b0);
                  issue(ACT_SACK, $urandom, $urandom, -1, pad_jitter(), 1'b0);
               end
            end
            issue(ACT_STOP, $urandom, $urandom, -1, pad_jitter(), 1'b0);
         end else begin
            issue($urandom_range(0, 7), $urandom, $urandom, -1, pad_jitter(),
                  $urandom_range(0, 3) == 0);
         end
      end
   endtask

   // wait until every tick is taken, every result checked and the engine idle
   task automatic settle();
      forever begin
         while (tick_backlog.size() != 0 || req_valid || expected_status.size() != 0)
            @(negedge clock);
         if (eng_act == ACT_IDLE) break;
         repeat (64) push_tick(1'b0, $urandom, $urandom, $urandom, $urandom);
      end
      repeat (4) @(negedge clock);
   endtask

   task automatic set_phase_len(input logic [15:0] v);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_wdata <= v;
      do @(posedge clock); while (!csr_ready);
      phase_len = v;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // main sequence
   initial begin
      eng_act = ACT_IDLE;
      eng_phase = 5'd0;
      eng_tick = 16'd0;
      eng_shift = 8'd0;
      pin_scl = 1'b1;
      pin_sda = 1'b1;
      ack_seen = 1'b0;
      sack_lvl = 1'b1;
      read_latch = 8'd0;
      phase_len = PHASE_TICKS_RESET;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // short transaction at the reset phase length
      issue(ACT_START, 8'h00, 1'b0, -1, 1, 1'b0);
      issue(ACT_WRITE, 8'hA5, 1'b0, -1, 1, 1'b0);
      issue(ACT_RACK, 8'h00, 1'b0, 0, 1, 1'b0);
      issue(ACT_STOP, 8'h00, 1'b0, -1, 2, 1'b0);
      settle();

      // directed commands at one tick per phase
      set_phase_len(16'd1);
      issue(ACT_START, 8'h00, 1'b0, -1, 1, 1'b0);
      issue(ACT_WRITE, 8'hFF, 1'b1, -1, 1, 1'b0);
      issue(ACT_RACK, 8'h00, 1'b0, 0, 1, 1'b0);
      issue(ACT_WRITE, 8'h00, 1'b0, -1, 1, 1'b0);
      issue(ACT_RACK, 8'hFF, 1'b1, 1, 1, 1'b0);
      issue(ACT_READ, 8'h00, 1'b0, 1, 1, 1'b0);
      issue(ACT_SACK, 8'hFF, 1'b0, -1, 1, 1'b0);
      issue(ACT_READ, 8'hFF, 1'b1, 0, 1, 1'b0);
      issue(ACT_SACK, 8'h00, 1'b1, -1, 1, 1'b0);
      issue(ACT_STOP, 8'h00, 1'b0, -1, 1, 1'b0);
      // unknown codes while idle
      issue(3'd6, 8'h00, 1'b0, -1, 1, 1'b0);
      issue(3'd7, 8'hFF, 1'b1, -1, 1, 1'b0);
      // command while busy, then one landing on the done tick
      issue(ACT_START, 8'h00, 1'b0, -1, 1, 1'b1);
      issue(ACT_WRITE, 8'h5A, 1'b0, -1, -1, 1'b0);
      issue(ACT_STOP, 8'h00, 1'b0, -1, 1, 1'b0);
      issue(ACT_READ, 8'h00, 1'b0, -1, 0, 1'b0);
      issue(ACT_RACK, 8'h00, 1'b0, -1, 1, 1'b0);
      issue(ACT_STOP, 8'h00, 1'b0, -1, 2, 1'b0);
      settle();

      // random traffic over several phase lengths, zero acting as one
      noise_on = 1'b1;
      random_traffic(200);
      settle();
      set_phase_len(16'd0);
      random_traffic(100);
      settle();
      set_phase_len(16'd2);
      random_traffic(150);
      settle();
      set_phase_len(16'd3);
      random_traffic(100);
      settle();

      // longer phase length, no idling from here on
      quiet = 1'b1;
      noise_on = 1'b0;
      set_phase_len(16'd7);
      issue(ACT_STOP, $urandom, $urandom, -1, 2, 1'b0);
      settle();
      set_phase_len(16'd1);
      noise_on = 1'b1;
      random_traffic(100);
      settle();

      repeat (10) @(negedge clock);
      if (fail_count == 0 && expected_status.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // watchdog
   initial begin
      #50ms;
      $display("TEST FAILED");
      $finish;
   end

endmodule

[filelist.f]
rtl/core/i2cbe_pkg.sv
rtl/core/i2cbe_step.sv
rtl/core/i2c_master_bit_engine_unit.sv
tb/i2c_master_bit_engine_unit_tb.sv
